// ----- design/adl_pkg.sv -----
// adl_pkg: shared widths, codes and types for the array doubly linked list
// used by adl_free_scan and array_doubly_linked_list; depends on nothing
package adl_pkg;

   localparam int ACTION_W = 4;
   localparam int POS_W    = 4;
   localparam int WORD_W   = 64;
   localparam int AMOUNT_W = 32;
   localparam int STATUS_W = 2;
   localparam int SLOT_W   = 4;
   localparam int COUNT_W  = 5;

   // most results one readout may give
   localparam int MAX_RESULTS = 16;

   // free-slot search looks at this many used marks per cycle
   localparam int CHUNK_W     = 8;
   localparam int CHUNK_IDX_W = 3;

   localparam logic [ACTION_W-1:0] ACT_ADD_HEAD  = 4'd0;
   localparam logic [ACTION_W-1:0] ACT_ADD_AFTER = 4'd1;
   localparam logic [ACTION_W-1:0] ACT_ADD_TAIL  = 4'd2;
   localparam logic [ACTION_W-1:0] ACT_DEL_HEAD  = 4'd3;
   localparam logic [ACTION_W-1:0] ACT_DEL_AFTER = 4'd4;
   localparam logic [ACTION_W-1:0] ACT_DEL_TAIL  = 4'd5;
   localparam logic [ACTION_W-1:0] ACT_CLEAR     = 4'd6;
   localparam logic [ACTION_W-1:0] ACT_READ_FWD  = 4'd7;
   localparam logic [ACTION_W-1:0] ACT_READ_REV  = 4'd8;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_INVALID = 2'd3;

   typedef struct packed {
      logic [WORD_W-1:0]   name;
      logic [WORD_W-1:0]   date;
      logic [AMOUNT_W-1:0] amount;
   } payload_type;

endpackage

// ----- design/adl_ram.sv -----
// adl_ram: generic single-write, single-read ram with registered read data
// no dependencies
module adl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// ----- design/adl_free_scan.sv -----
// adl_free_scan: finds the lowest free slot, one chunk of used marks a cycle
// depends on adl_pkg for the chunk size
module adl_free_scan
   import adl_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        scan_start,
   input  logic [CAPACITY-1:0]         used,
   output logic                        found,
   output logic [$clog2(CAPACITY)-1:0] found_slot
);

   localparam int SW  = $clog2(CAPACITY);
   localparam int NCH = (CAPACITY + CHUNK_W - 1) / CHUNK_W;
   localparam int CKW = (NCH > 1) ? $clog2(NCH) : 1;

   logic [NCH*CHUNK_W-1:0] used_pad;
   logic [CHUNK_W-1:0]     free_bits;
   logic [CHUNK_IDX_W-1:0] bit_idx;
   logic [CKW-1:0]         chunk_ff;
   logic                   active_ff;

   // slots past the end count as used so they are never picked
   for (genvar i = 0; i < NCH*CHUNK_W; i++) begin : g_pad
      if (i < CAPACITY) begin : g_real
         assign used_pad[i] = used[i];
      end else begin : g_fill
         assign used_pad[i] = 1'b1;
      end
   end

   assign free_bits = ~used_pad[chunk_ff*CHUNK_W +: CHUNK_W];

   always_comb begin
      bit_idx = '0;
      for (int i = CHUNK_W-1; i >= 0; i--) begin
         if (free_bits[i]) begin
            bit_idx = CHUNK_IDX_W'(i);
         end
      end
   end

   assign found      = active_ff && (|free_bits);
   assign found_slot = SW'({chunk_ff, bit_idx});

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         chunk_ff  <= '0;
      end else if (scan_start) begin
         active_ff <= 1'b1;
         chunk_ff  <= '0;
      end else if (active_ff) begin
         if (found) begin
            active_ff <= 1'b0;
         end else if (chunk_ff == CKW'(NCH-1)) begin
            chunk_ff <= '0;
         end else begin
            chunk_ff <= chunk_ff + CKW'(1);
         end
      end
   end

endmodule

// ----- design/array_doubly_linked_list.sv -----
// array_doubly_linked_list: doubly linked list kept in a fixed slot array
// depends on adl_pkg, adl_ram and adl_free_scan
//
// A command is taken on a rising edge with start high and busy low; the
// req_ ports carry the action, the position and the payload of a new entry.
// busy stays high until the last result word of that command is out.
// Each result word is on the rsp_ ports for one cycle with rsp_strobe high;
// the receiver cannot stall, so nothing waits on it.
// Adds take the lowest free slot from one shared chunk scanner, which walks
// the used marks eight slots at a time; reads walk the list forward or in
// reverse with one payload/link ram read per entry; errors, empty reads
// and a delete after the tail give a single status word.
// Links and payload live in rams with one read and one write port; the
// sequencer touches one link per ram per cycle.
// Reset (and the clear action) empties the list at once: used marks, head,
// tail and count are flip-flops; stale link and payload words of free slots
// are never read.
module array_doubly_linked_list
   import adl_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [ACTION_W-1:0]        req_action,
   input  logic [POS_W-1:0]           req_position,
   input  logic [WORD_W-1:0]          req_name_word,
   input  logic [WORD_W-1:0]          req_date_word,
   input  logic signed [AMOUNT_W-1:0] req_amount,
   output logic                       rsp_strobe,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [SLOT_W-1:0]          rsp_slot,
   output logic [WORD_W-1:0]          rsp_entry_name,
   output logic [WORD_W-1:0]          rsp_entry_date,
   output logic signed [AMOUNT_W-1:0] rsp_entry_amount,
   output logic [COUNT_W-1:0]         rsp_entry_count,
   output logic                       rsp_last
);

   localparam int SW = $clog2(CAPACITY);
   localparam int LW = $clog2(CAPACITY + 1);
   localparam int KW = $clog2(MAX_RESULTS);
   localparam int PW = $bits(payload_type);
   localparam logic [LW-1:0] NONE = LW'(CAPACITY);

   typedef enum logic [3:0] {
      S_IDLE, S_DEC, S_ADD_RD, S_SCAN, S_ADD_W1, S_ADD_W2,
      S_DEL_FD, S_DEL_FC, S_DEL_RD, S_DEL_NX, S_DEL_W,
      S_RD_ISSUE, S_RD_EMIT, S_RESP
   } state_type;

   state_type           state_ff;
   logic [ACTION_W-1:0] act_ff;
   logic [POS_W-1:0]    pos_ff;
   payload_type         pay_ff;
   logic [LW-1:0]       head_ff, tail_ff, count_ff;
   logic [CAPACITY-1:0] used_ff;
   logic [LW-1:0]       p_ff, d_ff, nx_ff;
   logic [KW-1:0]       k_ff;
   logic [STATUS_W-1:0] st_ff;

   logic                rsp_strobe_ff, rsp_last_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [SLOT_W-1:0]   rsp_slot_ff;
   logic [WORD_W-1:0]   rsp_name_ff, rsp_date_ff;
   logic [AMOUNT_W-1:0] rsp_amount_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;

   // ram ports
   logic [SW-1:0] raddr;
   logic [LW-1:0] next_rdata, prev_rdata;
   payload_type   pay_rdata;
   logic          nwe, pwe, dwe;
   logic [SW-1:0] nwaddr, pwaddr;
   logic [LW-1:0] nwdata, pwdata;

   logic          scan_start, scan_found;
   logic [SW-1:0] scan_slot;

   logic          pos_used, full, empty, p_valid, nx_valid, rd_fin;
   logic [SW-1:0] pos_slot;
   logic [LW-1:0] walk_nx;

   assign pos_slot = SW'(pos_ff);
   assign pos_used = (32'(pos_ff) < CAPACITY) && used_ff[pos_slot];
   assign full     = (count_ff == NONE);
   assign empty    = (count_ff == '0);
   assign p_valid  = (p_ff < NONE);
   assign nx_valid = (nx_ff < NONE);
   assign walk_nx  = (act_ff == ACT_READ_FWD) ? next_rdata : prev_rdata;
   assign rd_fin   = !(walk_nx < NONE) || (k_ff == KW'(MAX_RESULTS-1));

   // one shared read address for all three rams
   always_comb begin
      case (state_ff)
         S_ADD_RD, S_SCAN, S_DEL_FD: raddr = p_ff[SW-1:0];
         default:                    raddr = d_ff[SW-1:0];
      endcase
   end

   always_comb begin
      nwe    = 1'b0;
      pwe    = 1'b0;
      dwe    = 1'b0;
      nwaddr = d_ff[SW-1:0];
      pwaddr = d_ff[SW-1:0];
      nwdata = nx_ff;
      pwdata = p_ff;
      case (state_ff)
         S_ADD_W1: begin
            nwe = 1'b1;
            pwe = 1'b1;
            dwe = 1'b1;
         end
         S_ADD_W2: begin
            nwe    = p_valid;
            nwaddr = p_ff[SW-1:0];
            nwdata = d_ff;
            pwe    = nx_valid;
            pwaddr = nx_ff[SW-1:0];
            pwdata = d_ff;
         end
         S_DEL_W: begin
            nwe    = p_valid;
            nwaddr = p_ff[SW-1:0];
            nwdata = nx_ff;
            pwe    = nx_valid;
            pwaddr = nx_ff[SW-1:0];
            pwdata = p_ff;
         end
         default: begin
         end
      endcase
   end

   assign scan_start = (state_ff == S_ADD_RD);

   adl_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_next_ram (
      .clock (clock),
      .we    (nwe),
      .waddr (nwaddr),
      .wdata (nwdata),
      .raddr (raddr),
      .rdata (next_rdata)
   );

   adl_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_prev_ram (
      .clock (clock),
      .we    (pwe),
      .waddr (pwaddr),
      .wdata (pwdata),
      .raddr (raddr),
      .rdata (prev_rdata)
   );

   adl_ram #(.WIDTH(PW), .DEPTH(CAPACITY)) u_payload_ram (
      .clock (clock),
      .we    (dwe),
      .waddr (d_ff[SW-1:0]),
      .wdata (pay_ff),
      .raddr (raddr),
      .rdata (pay_rdata)
   );

   adl_free_scan #(.CAPACITY(CAPACITY)) u_free_scan (
      .clock      (clock),
      .reset      (reset),
      .scan_start (scan_start),
      .used       (used_ff),
      .found      (scan_found),
      .found_slot (scan_slot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         used_ff       <= '0;
         head_ff       <= NONE;
         tail_ff       <= NONE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  act_ff   <= req_action;
                  pos_ff   <= req_position;
                  pay_ff   <= '{name: req_name_word, date: req_date_word,
                                amount: req_amount};
                  state_ff <= S_DEC;
               end
            end
            S_DEC: begin
               st_ff    <= ST_OK;
               state_ff <= S_RESP;
               case (act_ff)
                  ACT_ADD_HEAD, ACT_ADD_TAIL: begin
                     if (full) begin
                        st_ff <= ST_FULL;
                     end else begin
                        // tail is none on an empty list, so add tail = add head
                        p_ff     <= (act_ff == ACT_ADD_TAIL) ? tail_ff : NONE;
                        state_ff <= S_ADD_RD;
                     end
                  end
                  ACT_ADD_AFTER: begin
                     if (!pos_used) begin
                        st_ff <= ST_INVALID;
                     end else if (full) begin
                        st_ff <= ST_FULL;
                     end else begin
                        p_ff     <= LW'(pos_ff);
                        state_ff <= S_ADD_RD;
                     end
                  end
                  ACT_DEL_HEAD: begin
                     if (empty) begin
                        st_ff <= ST_EMPTY;
                     end else begin
                        p_ff     <= NONE;
                        d_ff     <= head_ff;
                        state_ff <= S_DEL_RD;
                     end
                  end
                  ACT_DEL_AFTER: begin
                     if (empty) begin
                        st_ff <= ST_EMPTY;
                     end else if (!pos_used) begin
                        st_ff <= ST_INVALID;
                     end else begin
                        p_ff     <= LW'(pos_ff);
                        state_ff <= S_DEL_FD;
                     end
                  end
                  ACT_DEL_TAIL: begin
                     if (empty) begin
                        st_ff <= ST_EMPTY;
                     end else begin
                        d_ff     <= tail_ff;
                        state_ff <= S_DEL_RD;
                     end
                  end
                  ACT_CLEAR: begin
                     used_ff  <= '0;
                     head_ff  <= NONE;
                     tail_ff  <= NONE;
                     count_ff <= '0;
                     d_ff     <= '0;
                  end
                  ACT_READ_FWD, ACT_READ_REV: begin
                     if (empty) begin
                        st_ff <= ST_EMPTY;
                     end else begin
                        d_ff     <= (act_ff == ACT_READ_FWD) ? head_ff : tail_ff;
                        k_ff     <= '0;
                        state_ff <= S_RD_ISSUE;
                     end
                  end
                  default: begin
                     st_ff <= ST_INVALID;
                  end
               endcase
            end
            S_ADD_RD: begin
               state_ff <= S_SCAN;
            end
            S_SCAN: begin
               if (scan_found) begin
                  d_ff     <= LW'(scan_slot);
                  nx_ff    <= p_valid ? next_rdata : head_ff;
                  state_ff <= S_ADD_W1;
               end
            end
            S_ADD_W1: begin
               state_ff <= S_ADD_W2;
            end
            S_ADD_W2: begin
               // used mark, count and head/tail move together
               used_ff[d_ff[SW-1:0]] <= 1'b1;
               count_ff <= count_ff + LW'(1);
               if (!p_valid) begin
                  head_ff <= d_ff;
               end
               if (!nx_valid) begin
                  tail_ff <= d_ff;
               end
               state_ff <= S_RESP;
            end
            S_DEL_FD: begin
               state_ff <= S_DEL_FC;
            end
            S_DEL_FC: begin
               // position is the tail: nothing after it
               if (!(next_rdata < NONE)) begin
                  st_ff    <= ST_INVALID;
                  state_ff <= S_RESP;
               end else begin
                  d_ff     <= next_rdata;
                  state_ff <= S_DEL_RD;
               end
            end
            S_DEL_RD: begin
               state_ff <= S_DEL_NX;
            end
            S_DEL_NX: begin
               nx_ff <= next_rdata;
               if (act_ff == ACT_DEL_TAIL) begin
                  p_ff <= prev_rdata;
               end
               state_ff <= S_DEL_W;
            end
            S_DEL_W: begin
               if (!p_valid) begin
                  head_ff <= nx_ff;
               end
               if (!nx_valid) begin
                  tail_ff <= p_ff;
               end
               used_ff[d_ff[SW-1:0]] <= 1'b0;
               count_ff <= count_ff - LW'(1);
               state_ff <= S_RESP;
            end
            S_RD_ISSUE: begin
               state_ff <= S_RD_EMIT;
            end
            S_RD_EMIT: begin
               rsp_strobe_ff <= 1'b1;
               rsp_status_ff <= ST_OK;
               rsp_slot_ff   <= SLOT_W'(d_ff);
               rsp_name_ff   <= pay_rdata.name;
               rsp_date_ff   <= pay_rdata.date;
               rsp_amount_ff <= pay_rdata.amount;
               rsp_count_ff  <= COUNT_W'(count_ff);
               rsp_last_ff   <= rd_fin;
               if (rd_fin) begin
                  state_ff <= S_IDLE;
               end else begin
                  d_ff     <= walk_nx;
                  k_ff     <= k_ff + KW'(1);
                  state_ff <= S_RD_ISSUE;
               end
            end
            S_RESP: begin
               rsp_strobe_ff <= 1'b1;
               rsp_status_ff <= st_ff;
               rsp_slot_ff   <= (st_ff == ST_OK) ? SLOT_W'(d_ff) : '0;
               rsp_name_ff   <= '0;
               rsp_date_ff   <= '0;
               rsp_amount_ff <= '0;
               rsp_count_ff  <= COUNT_W'(count_ff);
               rsp_last_ff   <= 1'b1;
               state_ff      <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_slot         = rsp_slot_ff;
   assign rsp_entry_name   = rsp_name_ff;
   assign rsp_entry_date   = rsp_date_ff;
   assign rsp_entry_amount = $signed(rsp_amount_ff);
   assign rsp_entry_count  = rsp_count_ff;
   assign rsp_last         = rsp_last_ff;

   // used marks and count must agree
   a_count_matches_used: assert property (@(posedge clock) disable iff (reset)
      $countones(used_ff) == 32'(count_ff))
      else $error("used marks disagree with entry count");

   // head is none exactly when the list is empty
   a_head_vs_count: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) == (head_ff == NONE))
      else $error("head link disagrees with entry count");

   // an error word is marked last: like any single-word command it is the only word
   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != ST_OK)) |-> rsp_last)
      else $error("error word not marked last");

   // an accepted command raises busy, which the design holds until its words are out
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted command did not raise busy");

endmodule
